// File: design/ptd_pkg.sv
// Shared widths, index tables and feature codes for the point-triangle distance pipeline.
package ptd_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int DOT_W   = PROD_W + 2;
  localparam int MUL_CW  = 35;
  localparam int P1_W    = 2 * DOT_W;
  localparam int GRAM_W  = P1_W + 1;
  localparam int P2_W    = DOT_W + GRAM_W;
  localparam int NUM_W   = P2_W + 2;
  localparam int QUO_W   = DOT_W;
  localparam int DIST_W  = 32;

  localparam int NVEC  = 6;
  localparam int NDOT  = 10;
  localparam int NMUL1 = 12;
  localparam int NMUL2 = 3;

  // difference vectors
  localparam int VEC_EA = 0;
  localparam int VEC_EB = 1;
  localparam int VEC_WV = 2;
  localparam int VEC_W1 = 3;
  localparam int VEC_W2 = 4;
  localparam int VEC_E2 = 5;

  // dot products
  localparam int DOT_A  = 0;
  localparam int DOT_B  = 1;
  localparam int DOT_C  = 2;
  localparam int DOT_D  = 3;
  localparam int DOT_E  = 4;
  localparam int DOT_F  = 5;
  localparam int DOT_G1 = 6;
  localparam int DOT_G2 = 7;
  localparam int DOT_H2 = 8;
  localparam int DOT_M2 = 9;

  localparam int DOT_U [NDOT] = '{VEC_EA, VEC_EA, VEC_EB, VEC_EA, VEC_EB,
                                  VEC_WV, VEC_W1, VEC_W2, VEC_E2, VEC_E2};
  localparam int DOT_V [NDOT] = '{VEC_EA, VEC_EB, VEC_EB, VEC_WV, VEC_WV,
                                  VEC_WV, VEC_W1, VEC_W2, VEC_E2, VEC_W1};

  // first multiply round
  localparam int MUL_AC = 0;
  localparam int MUL_BB = 1;
  localparam int MUL_BE = 2;
  localparam int MUL_CD = 3;
  localparam int MUL_BD = 4;
  localparam int MUL_AE = 5;
  localparam int MUL_FA = 6;
  localparam int MUL_DD = 7;
  localparam int MUL_FC = 8;
  localparam int MUL_EE = 9;
  localparam int MUL_GH = 10;
  localparam int MUL_MM = 11;

  localparam int MUL1_A [NMUL1] = '{DOT_A, DOT_B, DOT_B, DOT_C, DOT_B, DOT_A,
                                    DOT_F, DOT_D, DOT_F, DOT_E, DOT_G1, DOT_M2};
  localparam int MUL1_B [NMUL1] = '{DOT_C, DOT_B, DOT_E, DOT_D, DOT_D, DOT_E,
                                    DOT_A, DOT_D, DOT_C, DOT_E, DOT_H2, DOT_M2};

  typedef enum logic [2:0] {
    FEAT_V0,
    FEAT_V1,
    FEAT_V2,
    FEAT_E0,
    FEAT_E1,
    FEAT_E2,
    FEAT_FACE
  } feat_t;

endpackage

// File: design/ptd_if.sv
// Stream interfaces: query items in, distance results out.
interface ptd_in_if;
  logic                      valid;
  logic                      ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic signed [31:0] vert0_x;
  logic signed [31:0] vert0_y;
  logic signed [31:0] vert0_z;
  logic signed [31:0] vert1_x;
  logic signed [31:0] vert1_y;
  logic signed [31:0] vert1_z;
  logic signed [31:0] vert2_x;
  logic signed [31:0] vert2_y;
  logic signed [31:0] vert2_z;

  modport source (output valid, point_x, point_y, point_z, vert0_x, vert0_y, vert0_z,
                  vert1_x, vert1_y, vert1_z, vert2_x, vert2_y, vert2_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, vert0_x, vert0_y, vert0_z,
                vert1_x, vert1_y, vert1_z, vert2_x, vert2_y, vert2_z, output ready);
endinterface

interface ptd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] distance;
  logic        degenerate;

  modport source (output valid, distance, degenerate, input ready);
  modport sink (input valid, distance, degenerate, output ready);
endinterface

// File: design/point_triangle_distance.sv
// Top level of the point-to-triangle distance pipeline.
//
// Channel item carries a query point and three triangle vertices (signed
// fixed point); channel result returns the distance to the closest point of
// the triangle (unsigned, same scale, saturating) and a degenerate flag that
// is set when the triangle has zero area, in which case the distance is to
// vertex 0.
// One beat is accepted every cycle in which the pipeline advances. The stages are
// the differences and dot products, the first multiply round, the face
// numerator multiply, feature select, the bit-per-stage divider and the
// bit-per-stage square root.
// The whole pipeline advances together; when the result beat is held by the
// receiver, every stage holds and item.ready drops, so nothing is lost or
// repeated. Reset clears the valid bits only.
module point_triangle_distance (
  input  logic        clk,
  input  logic        rst,
  ptd_in_if.sink      item,
  ptd_out_if.source   result
);
  import ptd_pkg::*;

  localparam int M1_LAT  = (DOT_W + MUL_CW - 1) / MUL_CW;
  localparam int M2_LAT  = (GRAM_W + MUL_CW - 1) / MUL_CW;
  localparam int DOT_DLY = M1_LAT + 1;
  localparam int LAT     = 3 + M1_LAT + 1 + M2_LAT + 1 + QUO_W + DIST_W;

  typedef struct packed {
    feat_t                     feat;
    logic                      degen;
    logic signed [DOT_W-1:0]   f;
    logic signed [DOT_W-1:0]   g1;
    logic signed [DOT_W-1:0]   g2;
    logic signed [DOT_W-1:0]   a;
    logic signed [DOT_W-1:0]   c;
    logic signed [DOT_W-1:0]   h2;
    logic signed [GRAM_W-1:0]  gram;
    logic signed [GRAM_W-1:0]  ne0;
    logic signed [GRAM_W-1:0]  ne1;
    logic signed [GRAM_W-1:0]  ne2;
  } side_t;

  logic adv;
  logic [LAT-1:0] vld;

  assign adv          = ~vld[LAT-1] | result.ready;
  assign item.ready   = adv;
  assign result.valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], item.valid};
    end
  end

  logic signed [COORD_W-1:0] pnt [3];
  logic signed [COORD_W-1:0] vx0 [3];
  logic signed [COORD_W-1:0] vx1 [3];
  logic signed [COORD_W-1:0] vx2 [3];

  assign pnt = '{item.point_x, item.point_y, item.point_z};
  assign vx0 = '{item.vert0_x, item.vert0_y, item.vert0_z};
  assign vx1 = '{item.vert1_x, item.vert1_y, item.vert1_z};
  assign vx2 = '{item.vert2_x, item.vert2_y, item.vert2_z};

  // edge and offset vectors
  logic signed [DIFF_W-1:0] dv [NVEC][3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        dv[VEC_EA][k] <= DIFF_W'(vx1[k]) - DIFF_W'(vx0[k]);
        dv[VEC_EB][k] <= DIFF_W'(vx2[k]) - DIFF_W'(vx0[k]);
        dv[VEC_WV][k] <= DIFF_W'(vx0[k]) - DIFF_W'(pnt[k]);
        dv[VEC_W1][k] <= DIFF_W'(vx1[k]) - DIFF_W'(pnt[k]);
        dv[VEC_W2][k] <= DIFF_W'(vx2[k]) - DIFF_W'(pnt[k]);
        dv[VEC_E2][k] <= DIFF_W'(vx2[k]) - DIFF_W'(vx1[k]);
      end
    end
  end

  logic signed [PROD_W-1:0] prod [NDOT][3];
  logic signed [DOT_W-1:0]  dot3 [NDOT];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NDOT; i++) begin
        for (int k = 0; k < 3; k++) begin
          prod[i][k] <= PROD_W'(dv[DOT_U[i]][k]) * PROD_W'(dv[DOT_V[i]][k]);
        end
        dot3[i] <= DOT_W'(prod[i][0]) + DOT_W'(prod[i][1]) + DOT_W'(prod[i][2]);
      end
    end
  end

  logic signed [P1_W-1:0] p1 [NMUL1];

  for (genvar i = 0; i < NMUL1; i++) begin : g_mul1
    ptd_mul #(
      .A_W     (DOT_W),
      .B_W     (DOT_W),
      .CHUNK_W (MUL_CW)
    ) u_mul (
      .clk (clk),
      .en  (adv),
      .a   (dot3[MUL1_A[i]]),
      .b   (dot3[MUL1_B[i]]),
      .p   (p1[i])
    );
  end

  logic signed [DOT_W-1:0] dot_d [DOT_DLY][NDOT];
  logic signed [DOT_W-1:0] dot6  [NDOT];

  always_ff @(posedge clk) begin
    if (adv) begin
      dot_d[0] <= dot3;
      for (int j = 1; j < DOT_DLY; j++) begin
        dot_d[j] <= dot_d[j-1];
      end
    end
  end

  assign dot6 = dot_d[DOT_DLY-1];

  logic signed [GRAM_W-1:0] gram6;
  logic signed [GRAM_W-1:0] sn6;
  logic signed [GRAM_W-1:0] tn6;
  logic signed [GRAM_W-1:0] ne6 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      gram6  <= GRAM_W'(p1[MUL_AC]) - GRAM_W'(p1[MUL_BB]);
      sn6    <= GRAM_W'(p1[MUL_BE]) - GRAM_W'(p1[MUL_CD]);
      tn6    <= GRAM_W'(p1[MUL_BD]) - GRAM_W'(p1[MUL_AE]);
      ne6[0] <= GRAM_W'(p1[MUL_FA]) - GRAM_W'(p1[MUL_DD]);
      ne6[1] <= GRAM_W'(p1[MUL_FC]) - GRAM_W'(p1[MUL_EE]);
      ne6[2] <= GRAM_W'(p1[MUL_GH]) - GRAM_W'(p1[MUL_MM]);
    end
  end

  // face numerator terms: f*gram, d*s, e*t
  logic signed [DOT_W-1:0]  m2_a [NMUL2];
  logic signed [GRAM_W-1:0] m2_b [NMUL2];
  logic signed [P2_W-1:0]   p2   [NMUL2];

  assign m2_a = '{dot6[DOT_F], dot6[DOT_D], dot6[DOT_E]};
  assign m2_b = '{gram6, sn6, tn6};

  for (genvar i = 0; i < NMUL2; i++) begin : g_mul2
    ptd_mul #(
      .A_W     (DOT_W),
      .B_W     (GRAM_W),
      .CHUNK_W (MUL_CW)
    ) u_mul (
      .clk (clk),
      .en  (adv),
      .a   (m2_a[i]),
      .b   (m2_b[i]),
      .p   (p2[i])
    );
  end

  function automatic feat_t clamp_feat(input logic signed [DOT_W-1:0] m,
                                       input logic signed [DOT_W-1:0] lim,
                                       input feat_t hi_f, input feat_t edg_f);
    logic signed [DOT_W:0] neg;
    neg = -(DOT_W+1)'(m);
    if (m >= 0) begin
      return FEAT_V0;
    end else if (neg >= (DOT_W+1)'(lim)) begin
      return hi_f;
    end else begin
      return edg_f;
    end
  endfunction

  feat_t feat_c;
  logic  degen_c;

  always_comb begin
    logic signed [GRAM_W:0]  st_sum;
    logic signed [DOT_W+1:0] den2;
    logic signed [DOT_W+1:0] lo;
    logic signed [DOT_W+1:0] hi;
    logic                    sneg;
    logic                    tneg;
    st_sum  = (GRAM_W+1)'(sn6) + (GRAM_W+1)'(tn6);
    den2    = (DOT_W+2)'(dot6[DOT_A]) - ((DOT_W+2)'(dot6[DOT_B]) <<< 1)
              + (DOT_W+2)'(dot6[DOT_C]);
    sneg    = sn6 < 0;
    tneg    = tn6 < 0;
    lo      = '0;
    hi      = '0;
    degen_c = 1'b0;
    feat_c  = FEAT_V0;
    if (gram6 <= 0) begin
      degen_c = 1'b1;
    end else if (st_sum <= (GRAM_W+1)'(gram6)) begin
      if (sneg) begin
        if (tneg && dot6[DOT_D] < 0) begin
          feat_c = clamp_feat(dot6[DOT_D], dot6[DOT_A], FEAT_V1, FEAT_E0);
        end else begin
          feat_c = clamp_feat(dot6[DOT_E], dot6[DOT_C], FEAT_V2, FEAT_E1);
        end
      end else if (tneg) begin
        feat_c = clamp_feat(dot6[DOT_D], dot6[DOT_A], FEAT_V1, FEAT_E0);
      end else begin
        feat_c = FEAT_FACE;
      end
    end else if (sneg) begin
      lo = (DOT_W+2)'(dot6[DOT_B]) + (DOT_W+2)'(dot6[DOT_D]);
      hi = (DOT_W+2)'(dot6[DOT_C]) + (DOT_W+2)'(dot6[DOT_E]);
      if (hi > lo) begin
        feat_c = (hi - lo >= den2) ? FEAT_V1 : FEAT_E2;
      end else begin
        feat_c = clamp_feat(dot6[DOT_E], dot6[DOT_C], FEAT_V2, FEAT_E1);
      end
    end else if (tneg) begin
      lo = (DOT_W+2)'(dot6[DOT_B]) + (DOT_W+2)'(dot6[DOT_E]);
      hi = (DOT_W+2)'(dot6[DOT_A]) + (DOT_W+2)'(dot6[DOT_D]);
      if (hi > lo) begin
        feat_c = (hi - lo >= den2) ? FEAT_V2 : FEAT_E2;
      end else begin
        feat_c = clamp_feat(dot6[DOT_D], dot6[DOT_A], FEAT_V1, FEAT_E0);
      end
    end else begin
      lo = (DOT_W+2)'(dot6[DOT_B]) + (DOT_W+2)'(dot6[DOT_D]);
      hi = (DOT_W+2)'(dot6[DOT_C]) + (DOT_W+2)'(dot6[DOT_E]);
      if (hi - lo <= 0) begin
        feat_c = FEAT_V2;
      end else begin
        feat_c = (hi - lo >= den2) ? FEAT_V1 : FEAT_E2;
      end
    end
  end

  side_t side_c;
  side_t side_d [M2_LAT];
  side_t side10;

  assign side_c = '{feat: feat_c, degen: degen_c, f: dot6[DOT_F], g1: dot6[DOT_G1],
                    g2: dot6[DOT_G2], a: dot6[DOT_A], c: dot6[DOT_C], h2: dot6[DOT_H2],
                    gram: gram6, ne0: ne6[0], ne1: ne6[1], ne2: ne6[2]};

  always_ff @(posedge clk) begin
    if (adv) begin
      side_d[0] <= side_c;
      for (int j = 1; j < M2_LAT; j++) begin
        side_d[j] <= side_d[j-1];
      end
    end
  end

  assign side10 = side_d[M2_LAT-1];

  logic [NUM_W-1:0]  num_c;
  logic [GRAM_W-1:0] den_c;
  logic [NUM_W-1:0]  num11;
  logic [GRAM_W-1:0] den11;
  logic              degen11;

  always_comb begin
    logic signed [NUM_W-1:0] fs;
    fs = NUM_W'(p2[0]) + NUM_W'(p2[1]) + NUM_W'(p2[2]);
    if (side10.degen) begin
      num_c = NUM_W'(side10.f);
      den_c = GRAM_W'(1);
    end else begin
      unique case (side10.feat)
        FEAT_V0: begin
          num_c = NUM_W'(side10.f);
          den_c = GRAM_W'(1);
        end
        FEAT_V1: begin
          num_c = NUM_W'(side10.g1);
          den_c = GRAM_W'(1);
        end
        FEAT_V2: begin
          num_c = NUM_W'(side10.g2);
          den_c = GRAM_W'(1);
        end
        FEAT_E0: begin
          num_c = (side10.ne0 < 0) ? '0 : NUM_W'(side10.ne0);
          den_c = GRAM_W'(side10.a);
        end
        FEAT_E1: begin
          num_c = (side10.ne1 < 0) ? '0 : NUM_W'(side10.ne1);
          den_c = GRAM_W'(side10.c);
        end
        FEAT_E2: begin
          num_c = (side10.ne2 < 0) ? '0 : NUM_W'(side10.ne2);
          den_c = GRAM_W'(side10.h2);
        end
        FEAT_FACE: begin
          num_c = (fs < 0) ? '0 : fs;
          den_c = side10.gram;
        end
        default: begin
          num_c = '0;
          den_c = GRAM_W'(1);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num11   <= num_c;
      den11   <= den_c;
      degen11 <= side10.degen;
    end
  end

  ptd_root #(
    .NUM_W (NUM_W),
    .DEN_W (GRAM_W),
    .QUO_W (QUO_W),
    .OUT_W (DIST_W)
  ) u_root (
    .clk       (clk),
    .en        (adv),
    .num       (num11),
    .den       (den11),
    .degen_in  (degen11),
    .distance  (result.distance),
    .degen_out (result.degenerate)
  );

endmodule

// File: design/ptd_mul.sv
// Pipelined signed multiplier, one chunk of the b operand per stage.
module ptd_mul #(
  parameter int A_W     = 68,
  parameter int B_W     = 68,
  parameter int CHUNK_W = 35
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [A_W-1:0]   a,
  input  logic signed [B_W-1:0]   b,
  output logic signed [A_W+B_W-1:0] p
);

  localparam int NS   = (B_W + CHUNK_W - 1) / CHUNK_W;
  localparam int BX_W = NS * CHUNK_W;
  localparam int P_W  = A_W + B_W;
  localparam int AL_W = A_W / 2;
  localparam int AH_W = A_W - AL_W;

  logic signed [A_W-1:0]  a_r   [NS];
  logic signed [BX_W-1:0] b_r   [NS];
  logic signed [P_W-1:0]  acc_r [NS];

  for (genvar j = 0; j < NS; j++) begin : g_stage
    logic signed [A_W-1:0]          a_in;
    logic signed [BX_W-1:0]         b_in;
    logic signed [P_W-1:0]          acc_in;
    logic signed [CHUNK_W:0]        dig;
    logic signed [AL_W:0]           a_lo;
    logic signed [AH_W-1:0]         a_hi;
    logic signed [AL_W+CHUNK_W+1:0] part_lo;
    logic signed [AH_W+CHUNK_W:0]   part_hi;
    logic signed [A_W+CHUNK_W:0]    part;

    if (j == 0) begin : g_first
      assign a_in   = a;
      assign b_in   = BX_W'(b);
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_r[j-1];
      assign b_in   = b_r[j-1];
      assign acc_in = acc_r[j-1];
    end

    // top chunk carries the sign
    if (j == NS - 1) begin : g_top
      assign dig = {b_in[(j+1)*CHUNK_W-1], b_in[j*CHUNK_W +: CHUNK_W]};
    end else begin : g_low
      assign dig = {1'b0, b_in[j*CHUNK_W +: CHUNK_W]};
    end

    // a split in two halves, low half unsigned
    assign a_lo    = {1'b0, a_in[AL_W-1:0]};
    assign a_hi    = a_in[A_W-1:AL_W];
    assign part_lo = a_lo * dig;
    assign part_hi = a_hi * dig;
    assign part    = (A_W+CHUNK_W+1)'(part_lo) + ((A_W+CHUNK_W+1)'(part_hi) <<< AL_W);

    always_ff @(posedge clk) begin
      if (en) begin
        a_r[j]   <= a_in;
        b_r[j]   <= b_in;
        acc_r[j] <= acc_in + (P_W'(part) <<< (j * CHUNK_W));
      end
    end
  end

  assign p = acc_r[NS-1];

endmodule

// File: design/ptd_root.sv
// Pipelined restoring divide followed by a pipelined integer square root with saturation.
module ptd_root #(
  parameter int NUM_W  = 207,
  parameter int DEN_W  = 137,
  parameter int QUO_W  = 68,
  parameter int OUT_W  = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic             degen_in,
  output logic [OUT_W-1:0] distance,
  output logic             degen_out
);

  localparam int SQ_W = 2 * OUT_W;
  localparam int RM_W = OUT_W + 2;

  logic [DEN_W-1:0] rem_r [QUO_W];
  logic [QUO_W-1:0] nlo_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];
  logic             dg_r  [QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    logic [DEN_W-1:0] rem_in;
    logic [QUO_W-1:0] nlo_in;
    logic [QUO_W-1:0] quo_in;
    logic [DEN_W-1:0] den_in;
    logic             dg_in;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (j == 0) begin : g_first
      // quotient fits QUO_W bits, so the high part is already below den
      assign rem_in = DEN_W'(num >> QUO_W);
      assign nlo_in = num[QUO_W-1:0];
      assign quo_in = '0;
      assign den_in = den;
      assign dg_in  = degen_in;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign nlo_in = nlo_r[j-1];
      assign quo_in = quo_r[j-1];
      assign den_in = den_r[j-1];
      assign dg_in  = dg_r[j-1];
    end

    assign trial = {rem_in, nlo_in[QUO_W-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
        nlo_r[j] <= nlo_in << 1;
        quo_r[j] <= {quo_in[QUO_W-2:0], ge};
        den_r[j] <= den_in;
        dg_r[j]  <= dg_in;
      end
    end
  end

  logic [OUT_W-1:0] rt_r  [OUT_W];
  logic [RM_W-1:0]  rm_r  [OUT_W];
  logic [SQ_W-1:0]  sv_r  [OUT_W];
  logic             st_r  [OUT_W];
  logic             dgs_r [OUT_W];

  for (genvar j = 0; j < OUT_W; j++) begin : g_sqrt
    logic [OUT_W-1:0] rt_in;
    logic [RM_W-1:0]  rm_in;
    logic [SQ_W-1:0]  sv_in;
    logic             st_in;
    logic             dg_in;
    logic [RM_W+1:0]  trial_rem;
    logic [RM_W+1:0]  trial;
    logic             ge;

    if (j == 0) begin : g_first
      assign rt_in = '0;
      assign rm_in = '0;
      assign sv_in = quo_r[QUO_W-1][SQ_W-1:0];
      assign st_in = |quo_r[QUO_W-1][QUO_W-1:SQ_W];
      assign dg_in = dg_r[QUO_W-1];
    end else begin : g_next
      assign rt_in = rt_r[j-1];
      assign rm_in = rm_r[j-1];
      assign sv_in = sv_r[j-1];
      assign st_in = st_r[j-1];
      assign dg_in = dgs_r[j-1];
    end

    assign trial_rem = {rm_in, sv_in[SQ_W-1 -: 2]};
    assign trial     = (RM_W+2)'({rt_in, 2'b01});
    assign ge        = trial_rem >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rm_r[j]  <= ge ? RM_W'(trial_rem - trial) : RM_W'(trial_rem);
        rt_r[j]  <= {rt_in[OUT_W-2:0], ge};
        sv_r[j]  <= sv_in << 2;
        st_r[j]  <= st_in;
        dgs_r[j] <= dg_in;
      end
    end
  end

  assign distance  = st_r[OUT_W-1] ? '1 : rt_r[OUT_W-1];
  assign degen_out = dgs_r[OUT_W-1];

endmodule
